/* design/udp_txcs_pkg.sv */
// UDP transmit checksum: shared types and constants.
// Used by udp_txcs_accum and udp_transmit_checksum_top; depends on nothing.

package udp_txcs_pkg;

  // Sizing and protocol constants
  localparam int unsigned MAX_PAYLOAD = 1472;
  localparam int unsigned RAW_W       = 21;   // 12 words of up to 17 bits

  localparam logic [15:0] UDP_PROTO   = 16'd17;
  localparam logic [15:0] HDR_BYTES   = 16'd8;
  localparam logic [10:0] COUNT_MAX   = 11'h7FF;
  localparam logic [15:0] CSUM_ONES   = 16'hFFFF;

  // Result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_TOO_LARGE = 2'd1;
  localparam logic [1:0] STATUS_MISMATCH  = 2'd2;

  typedef struct packed {
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        last_item;
  } in_item_t;

  typedef struct packed {
    logic [15:0] checksum_value;
    logic [10:0] total_length;
    logic [1:0]  result_status;
  } out_item_t;

  // Unfolded datagram sum with its length and status, passed to the fold stage
  typedef struct packed {
    logic [RAW_W-1:0] raw_sum;
    logic [10:0]      total_length;
    logic [1:0]       result_status;
  } dgram_sum_t;

endpackage

/* design/udp_transmit_checksum_top.sv */
// UDP transmit checksum, top level: input register, accumulator, middle register,
// fold stage and output register. Depends on udp_txcs_pkg and udp_txcs_accum.

// Takes one request per cycle unless a last request waits on a full middle
// register: each payload byte costs a single add into the running sum, so bytes
// stream at one a clock with no gaps. A request with last_item set produces one
// result, summed into the middle register, then folded into the output register;
// other requests produce nothing. The input register feeds the accumulator, the
// whole pseudo header and UDP header are summed in one pass on the last request,
// and the fold, inversion and zero mapping happen in the stage before the output
// register. Addresses, ports and payload_length are taken from the last request.
// Status 1 (payload too large) returns checksum 0 and length 0; status 2
// (byte count mismatch) returns checksum 0 with the declared length.

module udp_transmit_checksum_top (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  udp_txcs_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output udp_txcs_pkg::out_item_t out_data
);

  udp_txcs_pkg::in_item_t   in_r;
  logic                     in_v_r;
  udp_txcs_pkg::dgram_sum_t acc_res;
  udp_txcs_pkg::dgram_sum_t mid_r;
  logic                     mid_v_r;
  udp_txcs_pkg::out_item_t  out_r, out_nxt;
  logic                     out_v_r;

  logic        out_free, mid_free, in_take, mid_load;
  logic [16:0] fold1;
  logic [16:0] fold2;
  logic [15:0] folded;
  logic [15:0] chk;

  assign out_free = !out_v_r || out_ready;
  assign mid_free = !mid_v_r || out_free;
  assign in_take  = in_v_r && (!in_r.last_item || mid_free);
  assign mid_load = in_take && in_r.last_item;
  assign in_ready = !in_v_r || in_take;

  udp_txcs_accum u_accum (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (in_take),
    .item  (in_r),
    .res   (acc_res)
  );

  // end-around carry folding of the raw sum down to 16 bits
  always_comb begin
    fold1  = 17'(mid_r.raw_sum[15:0]) + 17'(mid_r.raw_sum[udp_txcs_pkg::RAW_W-1:16]);
    fold2  = 17'(fold1[15:0]) + 17'(fold1[16]);
    folded = fold2[16] ? 16'd1 : fold2[15:0];
    chk    = ~folded;
    if (chk == 16'd0) begin
      chk = udp_txcs_pkg::CSUM_ONES;
    end
    out_nxt.checksum_value = (mid_r.result_status == udp_txcs_pkg::STATUS_OK) ? chk : 16'd0;
    out_nxt.total_length   = mid_r.total_length;
    out_nxt.result_status  = mid_r.result_status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      mid_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (mid_free) begin
        mid_v_r <= mid_load;
      end
      if (out_free) begin
        out_v_r <= mid_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (mid_load) begin
      mid_r <= acc_res;
    end
    if (mid_v_r && out_free) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

/* design/udp_txcs_accum.sv */
// Per-datagram accumulator: pairs payload bytes into words, keeps the running
// one's complement sum and byte count, and on the last item forms the raw sum.
// Depends on udp_txcs_pkg.

module udp_txcs_accum (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   take,
  input  udp_txcs_pkg::in_item_t item,
  output udp_txcs_pkg::dgram_sum_t res
);

  logic [16:0] sum_r, sum_nxt;
  logic [10:0] count_r, count_nxt;
  logic [7:0]  held_r, held_nxt;
  logic        odd_r, odd_nxt;
  logic        in_dg_r, in_dg_nxt;

  logic [16:0] cur_sum;
  logic [10:0] cur_count;
  logic [7:0]  cur_held;
  logic        cur_odd;
  logic [15:0] pair_word;
  logic [16:0] pair_fold;
  logic [15:0] pad_word;
  logic [10:0] upd_count;
  logic [7:0]  upd_held;
  logic        upd_odd;
  logic [15:0] udp_len;
  logic [16:0] tlen_full;

  always_comb begin
    // a new datagram starts from cleared state
    cur_sum   = in_dg_r ? sum_r   : 17'd0;
    cur_count = in_dg_r ? count_r : 11'd0;
    cur_held  = in_dg_r ? held_r  : 8'd0;
    cur_odd   = in_dg_r ? odd_r   : 1'b0;

    pair_word = (item.byte_valid && cur_odd) ? {cur_held, item.data_byte} : 16'd0;
    pair_fold = 17'({1'b0, cur_sum[15:0]} + 17'(pair_word)) + 17'(cur_sum[16]);
    pair_fold = 17'(pair_fold[15:0]) + 17'(pair_fold[16]);

    upd_odd   = item.byte_valid ? !cur_odd : cur_odd;
    upd_held  = (item.byte_valid && !cur_odd) ? item.data_byte : cur_held;
    upd_count = (item.byte_valid && cur_count != udp_txcs_pkg::COUNT_MAX)
                ? 11'(cur_count + 11'd1) : cur_count;
    pad_word  = upd_odd ? {upd_held, 8'd0} : 16'd0;

    udp_len   = 16'(udp_txcs_pkg::HDR_BYTES + item.payload_length);
    tlen_full = 17'(udp_txcs_pkg::HDR_BYTES) + 17'(item.payload_length);

    res.raw_sum = udp_txcs_pkg::RAW_W'(cur_sum)
                + udp_txcs_pkg::RAW_W'(pair_word)
                + udp_txcs_pkg::RAW_W'(pad_word)
                + udp_txcs_pkg::RAW_W'(item.source_address[31:16])
                + udp_txcs_pkg::RAW_W'(item.source_address[15:0])
                + udp_txcs_pkg::RAW_W'(item.dest_address[31:16])
                + udp_txcs_pkg::RAW_W'(item.dest_address[15:0])
                + udp_txcs_pkg::RAW_W'(udp_txcs_pkg::UDP_PROTO)
                + udp_txcs_pkg::RAW_W'(udp_len)
                + udp_txcs_pkg::RAW_W'(udp_len)
                + udp_txcs_pkg::RAW_W'(item.source_port)
                + udp_txcs_pkg::RAW_W'(item.dest_port);

    if (32'(item.payload_length) > udp_txcs_pkg::MAX_PAYLOAD) begin
      res.result_status = udp_txcs_pkg::STATUS_TOO_LARGE;
      res.total_length  = 11'd0;
    end else begin
      res.total_length  = (tlen_full > 17'(udp_txcs_pkg::COUNT_MAX))
                          ? udp_txcs_pkg::COUNT_MAX : tlen_full[10:0];
      res.result_status = (16'(upd_count) != item.payload_length)
                          ? udp_txcs_pkg::STATUS_MISMATCH : udp_txcs_pkg::STATUS_OK;
    end

    if (item.last_item) begin
      sum_nxt   = 17'd0;
      count_nxt = 11'd0;
      held_nxt  = 8'd0;
      odd_nxt   = 1'b0;
      in_dg_nxt = 1'b0;
    end else begin
      sum_nxt   = (item.byte_valid && cur_odd) ? pair_fold : cur_sum;
      count_nxt = upd_count;
      held_nxt  = upd_held;
      odd_nxt   = upd_odd;
      in_dg_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= 17'd0;
      count_r <= 11'd0;
      held_r  <= 8'd0;
      odd_r   <= 1'b0;
      in_dg_r <= 1'b0;
    end else if (take) begin
      sum_r   <= sum_nxt;
      count_r <= count_nxt;
      held_r  <= held_nxt;
      odd_r   <= odd_nxt;
      in_dg_r <= in_dg_nxt;
    end
  end

endmodule

/* tb/udp_txcs_check_pkg.sv */
// Checksum tracker for the UDP transmit checksum testbench: predicts each
// datagram's checksum, length and status and checks the block's results.
// Depends on udp_txcs_pkg for the request and result types and constants.

package udp_txcs_check_pkg;

  class datagram_checksum_tracker;

    // Datagram state as the block should hold it
    logic [31:0] word_sum;
    logic [10:0] bytes_seen;
    logic [7:0]  high_byte;
    bit          odd_byte;
    bit          open_dgram;

    udp_txcs_pkg::out_item_t expected_results[$];
    int unsigned errors;
    int unsigned results_seen;
    int unsigned n_ok;
    int unsigned n_too_large;
    int unsigned n_mismatch;

    function new();
      restart();
      errors       = 0;
      results_seen = 0;
      n_ok         = 0;
      n_too_large  = 0;
      n_mismatch   = 0;
    endfunction

    function void restart();
      word_sum   = '0;
      bytes_seen = '0;
      high_byte  = '0;
      odd_byte   = 1'b0;
      open_dgram = 1'b0;
    endfunction

    // one's complement add, kept folded
    static function logic [31:0] ones_add(logic [31:0] acc, logic [15:0] w);
      logic [31:0] s;
      s = acc + {16'h0, w};
      return {16'h0, s[15:0]} + {16'h0, s[31:16]};
    endfunction

    // pseudo header plus UDP header (checksum field zero) onto a partial sum
    static function logic [31:0] header_sum(logic [31:0] acc,
                                            udp_txcs_pkg::in_item_t r);
      logic [15:0] udp_len;
      logic [31:0] s;
      udp_len = udp_txcs_pkg::HDR_BYTES + r.payload_length;
      s = ones_add(acc, r.source_address[31:16]);
      s = ones_add(s, r.source_address[15:0]);
      s = ones_add(s, r.dest_address[31:16]);
      s = ones_add(s, r.dest_address[15:0]);
      s = ones_add(s, udp_txcs_pkg::UDP_PROTO);
      s = ones_add(s, udp_len);
      s = ones_add(s, r.source_port);
      s = ones_add(s, r.dest_port);
      s = ones_add(s, udp_len);
      s = ones_add(s, 16'h0000);
      return s;
    endfunction

    function void take_request(udp_txcs_pkg::in_item_t r);
      logic [31:0] total;
      logic [15:0] csum;
      int unsigned tlen;
      udp_txcs_pkg::out_item_t want;
      if (!open_dgram) restart();
      if (r.byte_valid) begin
        if (!odd_byte) begin
          high_byte = r.data_byte;
          odd_byte  = 1'b1;
        end else begin
          word_sum = ones_add(word_sum, {high_byte, r.data_byte});
          odd_byte = 1'b0;
        end
        if (bytes_seen != udp_txcs_pkg::COUNT_MAX) bytes_seen++;
      end
      if (!r.last_item) begin
        open_dgram = 1'b1;
        return;
      end
      total = odd_byte ? ones_add(word_sum, {high_byte, 8'h00}) : word_sum;
      want  = '0;
      if (32'(r.payload_length) > udp_txcs_pkg::MAX_PAYLOAD) begin
        want.result_status = udp_txcs_pkg::STATUS_TOO_LARGE;
        n_too_large++;
      end else begin
        tlen = 32'd8 + 32'(r.payload_length);
        want.total_length = (tlen > 32'(udp_txcs_pkg::COUNT_MAX))
                            ? udp_txcs_pkg::COUNT_MAX : tlen[10:0];
        if ({5'h0, bytes_seen} != r.payload_length) begin
          want.result_status = udp_txcs_pkg::STATUS_MISMATCH;
          n_mismatch++;
        end else begin
          want.result_status = udp_txcs_pkg::STATUS_OK;
          total = header_sum(total, r);
          csum  = ~total[15:0];
          want.checksum_value = (csum == 16'h0000) ? udp_txcs_pkg::CSUM_ONES : csum;
          n_ok++;
        end
      end
      expected_results.push_back(want);
      restart();
    endfunction

    task report(string what, logic [15:0] got, logic [15:0] want);
      errors++;
      if (errors <= 20)
        $display("ERROR result %0d %s: got %h, expected %h", results_seen, what, got, want);
    endtask

    task check_result(udp_txcs_pkg::out_item_t got);
      udp_txcs_pkg::out_item_t want;
      results_seen++;
      if (expected_results.size() == 0) begin
        report("with nothing outstanding", got.checksum_value, 16'h0);
        return;
      end
      want = expected_results.pop_front();
      if (got.checksum_value !== want.checksum_value)
        report("checksum_value", got.checksum_value, want.checksum_value);
      if (got.total_length !== want.total_length)
        report("total_length", {5'h0, got.total_length}, {5'h0, want.total_length});
      if (got.result_status !== want.result_status)
        report("result_status", {14'h0, got.result_status}, {14'h0, want.result_status});
    endtask

    function int unsigned outstanding();
      return expected_results.size();
    endfunction

  endclass

endpackage

/* tb/tb_top.sv */
// Top-level testbench for udp_transmit_checksum_top: drives datagrams of
// requests, stalls both channels at random and checks every result.
// Depends on udp_txcs_pkg, udp_txcs_check_pkg and the RTL.

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  udp_txcs_pkg::in_item_t  in_data;
  logic                    out_valid;
  logic                    out_ready;
  udp_txcs_pkg::out_item_t out_data;

  udp_txcs_check_pkg::datagram_checksum_tracker tracker = new();

  bit          steady = 1'b0;   // no idling on either side while set
  int unsigned useful_sent = 0;
  int unsigned dgrams_sent = 0;

  udp_transmit_checksum_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) tracker.take_request(in_data);
    if (rst_n && out_valid && out_ready) tracker.check_result(out_data);
  end

  // mostly no gap, some short ones, a few long
  function automatic int unsigned idle_len();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  initial begin : result_stall
    int unsigned gap;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      @(posedge clk);
      gap = idle_len();
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    #40ms;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_request(input udp_txcs_pkg::in_item_t req);
    int unsigned gap;
    in_data  <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (req.byte_valid || req.last_item) useful_sent++;
    gap = idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // nbytes payload requests; fixed repeats a 16-bit pattern, else random bytes.
  // noisy mixes in empty-marker requests and scrambles the header fields of
  // every request but the last, which may itself be an empty marker.
  task automatic send_datagram(input logic [31:0] src, input logic [31:0] dst,
                               input logic [15:0] sport, input logic [15:0] dport,
                               input logic [15:0] plen, input int unsigned nbytes,
                               input bit fixed, input logic [15:0] pattern,
                               input bit noisy);
    udp_txcs_pkg::in_item_t req;
    bit          marker_last;
    int unsigned k;
    marker_last = (nbytes == 0) || (noisy && $urandom_range(0, 2) == 0);
    dgrams_sent++;
    for (k = 0; k <= nbytes; k++) begin
      if (k == nbytes && !marker_last) break;
      req.last_item  = (k == nbytes) || (k == nbytes - 1 && !marker_last);
      req.byte_valid = (k != nbytes);
      if (req.byte_valid && noisy && $urandom_range(0, 3) == 0) begin
        req.source_address = $urandom;
        req.dest_address   = $urandom;
        req.source_port    = 16'($urandom);
        req.dest_port      = 16'($urandom);
        req.payload_length = 16'($urandom);
        req.data_byte      = 8'($urandom);
        req.byte_valid     = 1'b0;
        req.last_item      = 1'b0;
        send_request(req);
        req.byte_valid     = 1'b1;
        req.last_item      = (k == nbytes - 1 && !marker_last);
      end
      if (noisy && !req.last_item) begin
        req.source_address = $urandom;
        req.dest_address   = $urandom;
        req.source_port    = 16'($urandom);
        req.dest_port      = 16'($urandom);
        req.payload_length = 16'($urandom);
      end else begin
        req.source_address = src;
        req.dest_address   = dst;
        req.source_port    = sport;
        req.dest_port      = dport;
        req.payload_length = plen;
      end
      if (fixed && req.byte_valid) req.data_byte = k[0] ? pattern[7:0] : pattern[15:8];
      else req.data_byte = 8'($urandom);
      send_request(req);
    end
  endtask

  function automatic logic [15:0] payload_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return 16'($urandom_range(0, 24));
    if (r < 97) return 16'($urandom_range(25, 200));
    return 16'($urandom_range(201, 600));
  endfunction

  initial begin : stimulus
    udp_txcs_pkg::in_item_t probe;
    logic [31:0] hsum;
    logic [15:0] plen;
    int unsigned nbytes;
    int unsigned r;
    int unsigned target;
    bit          paused;

    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty datagrams, declared length right and wrong
    send_datagram('0, '0, '0, '0, 16'd0, 0, 1'b0, 16'h0, 1'b0);
    send_datagram('0, '0, '0, '0, 16'd1, 0, 1'b0, 16'h0, 1'b0);
    // single odd byte, all-ones fields
    send_datagram('1, '1, '1, '1, 16'd1, 1, 1'b1, 16'hFFFF, 1'b0);
    // payload word chosen so the sum is all ones: zero checksum sent as FFFF
    probe = '0;
    probe.source_address = 32'h0A00_0001;
    probe.dest_address   = 32'hC0A8_0001;
    probe.source_port    = 16'd1234;
    probe.dest_port      = 16'd80;
    probe.payload_length = 16'd2;
    hsum = udp_txcs_check_pkg::datagram_checksum_tracker::header_sum(32'h0, probe);
    send_datagram(probe.source_address, probe.dest_address, probe.source_port,
                  probe.dest_port, 16'd2, 2, 1'b1, 16'hFFFF - hsum[15:0], 1'b0);
    send_datagram($urandom, $urandom, 16'($urandom), 16'($urandom), 16'd3, 3, 1'b1,
                  16'h0, 1'b0);
    // too large, with and without bytes
    send_datagram($urandom, $urandom, 16'($urandom), 16'($urandom), 16'hFFFF, 1, 1'b0,
                  16'h0, 1'b0);
    send_datagram($urandom, $urandom, 16'($urandom), 16'($urandom),
                  16'(udp_txcs_pkg::MAX_PAYLOAD + 1), 0, 1'b0, 16'h0, 1'b0);
    // largest legal declared length with a short payload
    send_datagram($urandom, $urandom, 16'($urandom), 16'($urandom),
                  16'(udp_txcs_pkg::MAX_PAYLOAD), 2, 1'b0, 16'h0, 1'b0);
    // byte count short and long of the declared length
    send_datagram($urandom, $urandom, 16'($urandom), 16'($urandom), 16'd4, 2, 1'b0,
                  16'h0, 1'b0);
    send_datagram($urandom, $urandom, 16'($urandom), 16'($urandom), 16'd1, 3, 1'b0,
                  16'h0, 1'b0);
    // markers mixed in, scrambled headers before the last request
    send_datagram($urandom, $urandom, 16'($urandom), 16'($urandom), 16'd4, 4, 1'b0,
                  16'h0, 1'b1);

    target = useful_sent + 800;
    paused = 1'b0;
    while (useful_sent < target) begin
      if ($urandom_range(0, 7) == 0) steady = !steady;
      // hold the sender off once until every result is back
      if (!paused && useful_sent + 400 >= target) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.outstanding() != 0) @(posedge clk);
      end
      r    = $urandom_range(0, 99);
      plen = payload_size();
      if (r < 70) begin
        send_datagram($urandom, $urandom, 16'($urandom), 16'($urandom), plen, 32'(plen),
                      1'b0, 16'h0, 1'b0);
      end else if (r < 80) begin
        nbytes = $urandom_range(0, 1) ? 32'(plen) + $urandom_range(1, 3)
                                      : (plen > 3 ? 32'(plen) - $urandom_range(1, 3) : 0);
        send_datagram($urandom, $urandom, 16'($urandom), 16'($urandom), plen, nbytes,
                      1'b0, 16'h0, 1'b0);
      end else if (r < 88) begin
        send_datagram($urandom, $urandom, 16'($urandom), 16'($urandom),
                      16'($urandom_range(udp_txcs_pkg::MAX_PAYLOAD + 1, 65535)),
                      $urandom_range(0, 8), 1'b0, 16'h0, 1'b0);
      end else if (r < 95) begin
        send_datagram($urandom, $urandom, 16'($urandom), 16'($urandom), plen, 32'(plen),
                      1'b0, 16'h0, 1'b1);
      end else begin
        plen = $urandom_range(0, 1) ? 16'd0 : 16'($urandom);
        send_datagram($urandom, $urandom, 16'($urandom), 16'($urandom), plen, 0,
                      1'b0, 16'h0, 1'b0);
      end
    end

    in_valid <= 1'b0;
    steady = 1'b0;
    @(posedge clk);
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d payload and last requests in %0d datagrams, %0d results checked",
             useful_sent, dgrams_sent, tracker.results_seen);
    $display("Outcomes: %0d ok, %0d too large, %0d byte count mismatch",
             tracker.n_ok, tracker.n_too_large, tracker.n_mismatch);
    if (tracker.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
